@@ design/vvb_pkg.sv @@
package vvb_pkg;

   localparam int MAX_POINTS_Y   = 128;
   localparam int MAX_POINTS_Z   = 128;
   localparam int POINTS_X_LIMIT = 1024;
   localparam int RSP_FIFO_DEPTH = 32;

   localparam logic [1:0] CSR_POINTS_X  = 2'd0;
   localparam logic [1:0] CSR_POINTS_Y  = 2'd1;
   localparam logic [1:0] CSR_POINTS_Z  = 2'd2;
   localparam logic [1:0] CSR_THRESHOLD = 2'd3;

   // one slot of the corner-sum chain: running sum plus the terms still to add
   typedef struct packed {
      logic               valid;
      logic signed [34:0] acc;
      logic [7:0][31:0]   terms;
   } sum_stage_type;

   typedef struct packed {
      logic [9:0]  cell_x;
      logic [6:0]  cell_y;
      logic [6:0]  cell_z;
      logic        is_void;
      logic        is_boundary;
      logic [24:0] void_count;
      logic [24:0] boundary_count;
      logic        last_cell;
   } rsp_item_type;

endpackage

@@ design/vvb_ifs.sv @@
interface vvb_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] density;
   modport source (output valid, output density, input ready);
   modport sink   (input valid, input density, output ready);
endinterface

interface vvb_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  cell_x;
   logic [6:0]  cell_y;
   logic [6:0]  cell_z;
   logic        is_void;
   logic        is_boundary;
   logic [24:0] void_count;
   logic [24:0] boundary_count;
   logic        last_cell;
   modport source (output valid, output cell_x, output cell_y, output cell_z,
                   output is_void, output is_boundary, output void_count,
                   output boundary_count, output last_cell, input ready);
   modport sink   (input valid, input cell_x, input cell_y, input cell_z,
                   input is_void, input is_boundary, input void_count,
                   input boundary_count, input last_cell, output ready);
endinterface

interface vvb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/vvb_ram.sv @@
module vvb_ram #(
   parameter int ADDR_W = 1,
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/vvb_sum_cell.sv @@
module vvb_sum_cell #(
   parameter int META_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  vvb_pkg::sum_stage_type  stage_in,
   input  logic [META_W-1:0]       meta_in,
   output vvb_pkg::sum_stage_type  stage_out,
   output logic [META_W-1:0]       meta_out
);

   vvb_pkg::sum_stage_type stage_ff, stage_in_w;
   logic [META_W-1:0]      meta_ff;
   logic signed [34:0]     t0, t1;

   assign t0 = $signed({{3{stage_in.terms[0][31]}}, stage_in.terms[0]});
   assign t1 = $signed({{3{stage_in.terms[1][31]}}, stage_in.terms[1]});

   always_comb begin
      stage_in_w.valid = stage_in.valid;
      stage_in_w.acc   = stage_in.acc + t0 + t1;
      stage_in_w.terms = {64'd0, stage_in.terms[7:2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in_w.valid;
      end
      stage_ff.acc   <= stage_in_w.acc;
      stage_ff.terms <= stage_in_w.terms;
      meta_ff        <= meta_in;
   end

   assign stage_out = stage_ff;
   assign meta_out  = meta_ff;

endmodule

@@ design/voxel_void_boundary_classifier.sv @@
// channel  | dir | signals                                   | transfer
// ---------+-----+-------------------------------------------+--------------------
// req_ch   | in  | density                                   | valid && ready
// rsp_ch   | out | cell_x/y/z, is_void, is_boundary, counts, | valid && ready
//          |     | last_cell                                 |
// csr_ch   | in  | index, data                               | valid && ready (ready=1)
//
// One sample per cycle sustained while req ready holds; a sample reaches the result
// queue through the plane RAM, the row RAM, four corner-sum cells and the flag RAMs.
// Samples of the last x plane make two results each, and the result port drains one per
// cycle, so there the rate is set by the output port: req ready drops while the 32-entry
// result queue has no room reserved for two more results.
// Synchronous reset clears position, counts and queue; stores need no clearing pass.
// An output stall never stalls the pipeline; only req ready is held back.
module voxel_void_boundary_classifier #(
   parameter int MAX_POINTS_Y = vvb_pkg::MAX_POINTS_Y,
   parameter int MAX_POINTS_Z = vvb_pkg::MAX_POINTS_Z
) (
   input logic        clock,
   input logic        reset,
   vvb_req_if.sink    req_ch,
   vvb_rsp_if.source  rsp_ch,
   vvb_csr_if.sink    csr_ch
);

   localparam int YW    = $clog2(MAX_POINTS_Y);
   localparam int ZW    = $clog2(MAX_POINTS_Z);
   localparam int PYW   = $clog2(MAX_POINTS_Y + 1);
   localparam int PZW   = $clog2(MAX_POINTS_Z + 1);
   localparam int FROWS = (MAX_POINTS_Y + 1) / 3;
   localparam int FAW   = (FROWS > 1) ? $clog2(FROWS) : 1;
   localparam int FW    = MAX_POINTS_Z;
   localparam int FD    = vvb_pkg::RSP_FIFO_DEPTH;
   localparam int PW    = $clog2(FD);
   localparam int CW    = $clog2(FD + 1);

   typedef struct packed {
      logic [9:0]     x;
      logic [YW-1:0]  y;
      logic [ZW-1:0]  z;
      logic [1:0]     xm3;
      logic [1:0]     ym3;
      logic [FAW-1:0] yd3;
      logic           corner;
      logic           last_plane;
      logic           grid_end;
   } meta_type;

   localparam int MW = $bits(meta_type);

   function automatic logic [1:0] inc3(input logic [1:0] v);
      return (v == 2'd2) ? 2'd0 : v + 2'd1;
   endfunction

   // ---------------- configuration ----------------
   logic [10:0]        points_x_ff, points_x_in;
   logic [PYW-1:0]     points_y_ff, points_y_in;
   logic [PZW-1:0]     points_z_ff, points_z_in;
   logic signed [31:0] threshold_ff, threshold_in;
   logic               csr_we, grid_restart;

   assign csr_ch.ready = 1'b1;
   assign csr_we       = csr_ch.valid & csr_ch.ready;
   assign grid_restart = csr_we & (csr_ch.index != vvb_pkg::CSR_THRESHOLD);

   always_comb begin
      points_x_in  = points_x_ff;
      points_y_in  = points_y_ff;
      points_z_in  = points_z_ff;
      threshold_in = threshold_ff;
      if (csr_we) begin
         case (csr_ch.index)
            vvb_pkg::CSR_POINTS_X: begin
               if (csr_ch.data < 32'd2) points_x_in = 11'd2;
               else if (csr_ch.data > 32'(vvb_pkg::POINTS_X_LIMIT))
                  points_x_in = 11'(vvb_pkg::POINTS_X_LIMIT);
               else points_x_in = 11'(csr_ch.data);
            end
            vvb_pkg::CSR_POINTS_Y: begin
               if (csr_ch.data < 32'd2) points_y_in = PYW'(2);
               else if (csr_ch.data > 32'(MAX_POINTS_Y)) points_y_in = PYW'(MAX_POINTS_Y);
               else points_y_in = PYW'(csr_ch.data);
            end
            vvb_pkg::CSR_POINTS_Z: begin
               if (csr_ch.data < 32'd2) points_z_in = PZW'(2);
               else if (csr_ch.data > 32'(MAX_POINTS_Z)) points_z_in = PZW'(MAX_POINTS_Z);
               else points_z_in = PZW'(csr_ch.data);
            end
            vvb_pkg::CSR_THRESHOLD: threshold_in = $signed(csr_ch.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_x_ff  <= 11'd2;
         points_y_ff  <= PYW'(2);
         points_z_ff  <= PZW'(2);
         threshold_ff <= 32'sd0;
      end else begin
         points_x_ff  <= points_x_in;
         points_y_ff  <= points_y_in;
         points_z_ff  <= points_z_in;
         threshold_ff <= threshold_in;
      end
   end

   // ---------------- input position ----------------
   logic [9:0]     x_ff, x_in;
   logic [YW-1:0]  y_ff, y_in;
   logic [ZW-1:0]  z_ff, z_in;
   logic [1:0]     xm3_ff, xm3_in, ym3_ff, ym3_in;
   logic [FAW-1:0] yd3_ff, yd3_in;
   logic           accept, z_end, y_end;
   meta_type       meta0;
   logic [CW-1:0]  credit_ff, credit_in;

   assign req_ch.ready = (credit_ff <= CW'(FD - 2));
   assign accept       = req_ch.valid & req_ch.ready;
   assign z_end        = (PZW'(z_ff) == points_z_ff - PZW'(1));
   assign y_end        = (PYW'(y_ff) == points_y_ff - PYW'(1));

   always_comb begin
      meta0.x          = x_ff;
      meta0.y          = y_ff;
      meta0.z          = z_ff;
      meta0.xm3        = xm3_ff;
      meta0.ym3        = ym3_ff;
      meta0.yd3        = yd3_ff;
      meta0.corner     = (x_ff != 10'd0) & (y_ff != '0) & (z_ff != '0);
      meta0.last_plane = (11'(x_ff) == points_x_ff - 11'd1);
      meta0.grid_end   = meta0.last_plane & y_end & z_end;
   end

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      xm3_in = xm3_ff;
      ym3_in = ym3_ff;
      yd3_in = yd3_ff;
      if (grid_restart || (accept && meta0.grid_end)) begin
         x_in   = '0;
         y_in   = '0;
         z_in   = '0;
         xm3_in = '0;
         ym3_in = '0;
         yd3_in = '0;
      end else if (accept) begin
         if (z_end) begin
            z_in = '0;
            if (y_end) begin
               y_in   = '0;
               ym3_in = '0;
               yd3_in = '0;
               x_in   = x_ff + 10'd1;
               xm3_in = inc3(xm3_ff);
            end else begin
               y_in   = y_ff + YW'(1);
               ym3_in = inc3(ym3_ff);
               yd3_in = (ym3_ff == 2'd2) ? yd3_ff + FAW'(1) : yd3_ff;
            end
         end else begin
            z_in = z_ff + ZW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         y_ff   <= '0;
         z_ff   <= '0;
         xm3_ff <= '0;
         ym3_ff <= '0;
         yd3_ff <= '0;
      end else begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         xm3_ff <= xm3_in;
         ym3_ff <= ym3_in;
         yd3_ff <= yd3_in;
      end
   end

   // ---------------- sample window ----------------
   logic [31:0] plane_rdata;
   logic [63:0] line_rdata;
   logic        s1_valid_ff, s2_valid_ff;
   meta_type    s1_meta_ff, s2_meta_ff;
   logic [31:0] s1_dens_ff, s2_dens_ff, s2_prev_ff;
   logic [31:0] last_dens_ff, last_prev_ff;
   logic [63:0] last_line_ff;

   // previous x plane at (y,z); overwritten with this plane's sample
   vvb_ram #(.ADDR_W(YW + ZW), .DATA_W(32)) u_plane_ram (
      .clock (clock),
      .we    (accept),
      .waddr ({y_ff, z_ff}),
      .wdata (req_ch.density),
      .raddr ({y_ff, z_ff}),
      .rdata (plane_rdata)
   );

   // one row back: {current plane, previous plane} at (y-1,z)
   vvb_ram #(.ADDR_W(ZW), .DATA_W(64)) u_line_ram (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_meta_ff.z),
      .wdata ({s1_dens_ff, plane_rdata}),
      .raddr (s1_meta_ff.z),
      .rdata (line_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff <= meta0;
      s1_dens_ff <= req_ch.density;
      s2_meta_ff <= s1_meta_ff;
      s2_dens_ff <= s1_dens_ff;
      s2_prev_ff <= plane_rdata;
      if (s2_valid_ff) begin
         last_dens_ff <= s2_dens_ff;
         last_prev_ff <= s2_prev_ff;
         last_line_ff <= line_rdata;
      end
   end

   // ---------------- corner-sum chain ----------------
   vvb_pkg::sum_stage_type stage_w [5];
   logic [MW-1:0]          meta_w  [5];

   always_comb begin
      stage_w[0].valid = s2_valid_ff;
      stage_w[0].acc   = '0;
      stage_w[0].terms = {line_rdata[63:32], last_line_ff[63:32], s2_dens_ff, last_dens_ff,
                          line_rdata[31:0], last_line_ff[31:0], s2_prev_ff, last_prev_ff};
      meta_w[0]        = MW'(s2_meta_ff);
   end

   for (genvar c = 0; c < 4; c++) begin : g_sum
      vvb_sum_cell #(.META_W(MW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage_w[c]),
         .meta_in   (meta_w[c]),
         .stage_out (stage_w[c+1]),
         .meta_out  (meta_w[c+1])
      );
   end

   // ---------------- void flag and flag planes ----------------
   meta_type           m6;
   logic signed [34:0] thr8;
   logic               void_new, cell6, flag_we;
   logic [YW-1:0]      cj6;
   logic [ZW-1:0]      ck6;
   logic [1:0]         s_i, s_im1, s_new, b_c, b_u, b_d;
   logic [FAW-1:0]     cj_div, cjm1_div;
   logic [FW-1:0]      rowacc_ff, rowacc_in, row_word;
   logic [FW-1:0]      flag_rd [3][3];

   assign m6       = meta_type'(meta_w[4]);
   assign thr8     = $signed({threshold_ff, 3'b000});
   assign void_new = (stage_w[4].acc <= thr8);
   assign cell6    = stage_w[4].valid & m6.corner;
   assign cj6      = m6.y - YW'(1);
   assign ck6      = m6.z - ZW'(1);
   assign s_im1    = m6.xm3;
   assign s_i      = inc3(m6.xm3);
   assign s_new    = inc3(inc3(m6.xm3));
   assign b_d      = m6.ym3;
   assign b_u      = inc3(m6.ym3);
   assign b_c      = inc3(inc3(m6.ym3));
   assign cj_div   = (m6.ym3 == 2'd0) ? m6.yd3 - FAW'(1) : m6.yd3;
   assign cjm1_div = (m6.ym3 == 2'd2) ? m6.yd3 : m6.yd3 - FAW'(1);
   assign flag_we  = cell6 & (PZW'(ck6) == points_z_ff - PZW'(2));

   always_comb begin
      row_word      = rowacc_ff;
      row_word[ck6] = void_new;
      rowacc_in     = cell6 ? row_word : rowacc_ff;
   end

   always_ff @(posedge clock) begin
      rowacc_ff <= rowacc_in;
   end

   // plane slot = x mod 3, bank = row mod 3, one row of flags per word
   for (genvar s = 0; s < 3; s++) begin : g_slot
      for (genvar b = 0; b < 3; b++) begin : g_bank
         logic [FAW-1:0] raddr_g;
         logic           we_g;
         always_comb begin
            if (s_im1 == 2'(s)) raddr_g = cj_div;
            else if (b_d == 2'(b)) raddr_g = m6.yd3;
            else if (b_c == 2'(b)) raddr_g = cj_div;
            else raddr_g = cjm1_div;
         end
         assign we_g = flag_we & (s_new == 2'(s)) & (b_c == 2'(b));
         vvb_ram #(.ADDR_W(FAW), .DATA_W(FW)) u_flag_ram (
            .clock (clock),
            .we    (we_g),
            .waddr (cj_div),
            .wdata (row_word),
            .raddr (raddr_g),
            .rdata (flag_rd[s][b])
         );
      end
   end

   // ---------------- classify and report ----------------
   logic        s7_valid_ff, s7_void_ff;
   meta_type    s7_meta_ff;
   logic [1:0]  s7_si_ff, s7_sim1_ff, s7_bc_ff, s7_bu_ff, s7_bd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= stage_w[4].valid;
      end
   end

   always_ff @(posedge clock) begin
      s7_meta_ff <= m6;
      s7_void_ff <= void_new;
      s7_si_ff   <= s_i;
      s7_sim1_ff <= s_im1;
      s7_bc_ff   <= b_c;
      s7_bu_ff   <= b_u;
      s7_bd_ff   <= b_d;
   end

   logic [FW-1:0]         center, up_row, down_row, back_row;
   logic [YW-1:0]         cj7;
   logic [ZW-1:0]         ck7;
   logic                  rep_a, rep_b, va, ba, edge_a;
   logic [24:0]           void_total_ff, void_total_in, boundary_total_ff, boundary_total_in;
   logic [24:0]           v1, b1, v2, b2;
   vvb_pkg::rsp_item_type item_a, item_b, item_first;
   logic [1:0]            npush;

   assign center   = flag_rd[s7_si_ff][s7_bc_ff];
   assign up_row   = flag_rd[s7_si_ff][s7_bu_ff];
   assign down_row = flag_rd[s7_si_ff][s7_bd_ff];
   assign back_row = flag_rd[s7_sim1_ff][s7_bc_ff];
   assign cj7      = s7_meta_ff.y - YW'(1);
   assign ck7      = s7_meta_ff.z - ZW'(1);
   assign rep_a    = s7_valid_ff & s7_meta_ff.corner & (s7_meta_ff.x >= 10'd2);
   assign rep_b    = s7_valid_ff & s7_meta_ff.corner & s7_meta_ff.last_plane;
   assign va       = center[ck7];
   assign edge_a   = (s7_meta_ff.x == 10'd2) | (cj7 == '0) | (ck7 == '0) |
                     (PYW'(cj7) == points_y_ff - PYW'(2)) |
                     (PZW'(ck7) == points_z_ff - PZW'(2));
   assign ba       = va & (edge_a | ~back_row[ck7] | ~s7_void_ff | ~up_row[ck7] |
                           ~down_row[ck7] | ~center[ck7 - ZW'(1)] | ~center[ck7 + ZW'(1)]);

   assign v1 = void_total_ff + 25'(rep_a & va);
   assign b1 = boundary_total_ff + 25'(rep_a & ba);
   assign v2 = v1 + 25'(rep_b & s7_void_ff);
   assign b2 = b1 + 25'(rep_b & s7_void_ff);

   always_comb begin
      item_a.cell_x         = s7_meta_ff.x - 10'd2;
      item_a.cell_y         = 7'(cj7);
      item_a.cell_z         = 7'(ck7);
      item_a.is_void        = va;
      item_a.is_boundary    = ba;
      item_a.void_count     = v1;
      item_a.boundary_count = b1;
      item_a.last_cell      = 1'b0;
      // last x plane cells are grid edge cells, so boundary equals void
      item_b.cell_x         = s7_meta_ff.x - 10'd1;
      item_b.cell_y         = 7'(cj7);
      item_b.cell_z         = 7'(ck7);
      item_b.is_void        = s7_void_ff;
      item_b.is_boundary    = s7_void_ff;
      item_b.void_count     = v2;
      item_b.boundary_count = b2;
      item_b.last_cell      = s7_meta_ff.grid_end;
      item_first            = rep_a ? item_a : item_b;
      npush                 = 2'(rep_a) + 2'(rep_b);
   end

   always_comb begin
      void_total_in     = void_total_ff;
      boundary_total_in = boundary_total_ff;
      if (grid_restart || (rep_b && s7_meta_ff.grid_end)) begin
         void_total_in     = '0;
         boundary_total_in = '0;
      end else if (s7_valid_ff) begin
         void_total_in     = v2;
         boundary_total_in = b2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         void_total_ff     <= '0;
         boundary_total_ff <= '0;
      end else begin
         void_total_ff     <= void_total_in;
         boundary_total_ff <= boundary_total_in;
      end
   end

   // ---------------- result queue ----------------
   vvb_pkg::rsp_item_type fifo_ff [FD];
   vvb_pkg::rsp_item_type head;
   logic [PW-1:0]         wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  pop;

   assign pop  = rsp_ch.valid & rsp_ch.ready;
   assign head = fifo_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         fifo_ff[wptr_ff] <= item_first;
      end
      if (npush == 2'd2) begin
         fifo_ff[wptr_ff + PW'(1)] <= item_b;
      end
   end

   // credit holds queued results plus two per sample still in the pipeline
   always_comb begin
      wptr_in   = wptr_ff + PW'(npush);
      rptr_in   = pop ? rptr_ff + PW'(1) : rptr_ff;
      count_in  = count_ff + CW'(npush) - CW'(pop);
      credit_in = credit_ff + (accept ? CW'(2) : CW'(0)) - CW'(pop) -
                  (s7_valid_ff ? CW'(2'd2 - npush) : CW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff   <= '0;
         rptr_ff   <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         wptr_ff   <= wptr_in;
         rptr_ff   <= rptr_in;
         count_ff  <= count_in;
         credit_ff <= credit_in;
      end
   end

   assign rsp_ch.valid          = (count_ff != '0);
   assign rsp_ch.cell_x         = head.cell_x;
   assign rsp_ch.cell_y         = head.cell_y;
   assign rsp_ch.cell_z         = head.cell_z;
   assign rsp_ch.is_void        = head.is_void;
   assign rsp_ch.is_boundary    = head.is_boundary;
   assign rsp_ch.void_count     = head.void_count;
   assign rsp_ch.boundary_count = head.boundary_count;
   assign rsp_ch.last_cell      = head.last_cell;

endmodule

@@ design/vvb_checker.sv @@
module vvb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  rsp_cell_x,
   input logic [6:0]  rsp_cell_y,
   input logic [6:0]  rsp_cell_z,
   input logic        rsp_is_void,
   input logic        rsp_is_boundary,
   input logic [24:0] rsp_void_count,
   input logic [24:0] rsp_boundary_count,
   input logic        rsp_last_cell
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_x) && $stable(rsp_cell_y) &&
      $stable(rsp_cell_z) && $stable(rsp_is_void) && $stable(rsp_is_boundary) &&
      $stable(rsp_void_count) && $stable(rsp_boundary_count) && $stable(rsp_last_cell))
      else $error("result changed during stall");

   a_boundary_void: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_boundary |-> rsp_is_void)
      else $error("boundary flag on non-void cell");

   a_count_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_boundary_count <= rsp_void_count)
      else $error("boundary count above void count");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind voxel_void_boundary_classifier vvb_checker u_vvb_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_cell_x         (rsp_ch.cell_x),
   .rsp_cell_y         (rsp_ch.cell_y),
   .rsp_cell_z         (rsp_ch.cell_z),
   .rsp_is_void        (rsp_ch.is_void),
   .rsp_is_boundary    (rsp_ch.is_boundary),
   .rsp_void_count     (rsp_ch.void_count),
   .rsp_boundary_count (rsp_ch.boundary_count),
   .rsp_last_cell      (rsp_ch.last_cell)
);

@@ bench/voxel_classifier_checker.sv @@
`timescale 1ns / 1ps

module voxel_classifier_checker (
   input  logic      clock,
   input  logic      reset,
   vvb_req_if        req_ch,
   vvb_rsp_if        rsp_ch,
   vvb_csr_if        csr_ch,
   output int        error_count,
   output int        pending
);

   localparam int PLANE = vvb_pkg::MAX_POINTS_Y * vvb_pkg::MAX_POINTS_Z;

   int signed    samples [2*PLANE];
   bit           void_flags [3*PLANE];
   int unsigned  pts_x, pts_y, pts_z;
   int unsigned  at_x, at_y, at_z;
   int unsigned  voids_seen, edges_seen;
   int signed    cutoff;
   vvb_pkg::rsp_item_type cells_due [$];

   function automatic int unsigned clamp_pts(logic [31:0] v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int flag_at(int unsigned i, int unsigned j, int unsigned k);
      return (i % 3) * PLANE + j * vvb_pkg::MAX_POINTS_Z + k;
   endfunction

   function automatic longint sample_of(int unsigned x, int unsigned y, int unsigned z);
      return longint'(samples[(x & 1) * PLANE + y * vvb_pkg::MAX_POINTS_Z + z]);
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0t] cell mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      error_count++;
   endtask

   task automatic restart_grid();
      at_x = 0;
      at_y = 0;
      at_z = 0;
      voids_seen = 0;
      edges_seen = 0;
   endtask

   // finalise cell (i,j,k): boundary by grid edge or six face neighbors
   task automatic finalise_cell(int unsigned i, int unsigned j, int unsigned k, bit last);
      vvb_pkg::rsp_item_type c;
      bit v, b;
      v = void_flags[flag_at(i, j, k)];
      b = 0;
      if (v) begin
         if (i == 0 || i == pts_x - 2 || j == 0 || j == pts_y - 2 || k == 0 || k == pts_z - 2)
            b = 1;
         else
            b = !void_flags[flag_at(i - 1, j, k)] || !void_flags[flag_at(i + 1, j, k)] ||
                !void_flags[flag_at(i, j - 1, k)] || !void_flags[flag_at(i, j + 1, k)] ||
                !void_flags[flag_at(i, j, k - 1)] || !void_flags[flag_at(i, j, k + 1)];
         voids_seen = (voids_seen + 1) & 32'h1FF_FFFF;
         if (b) edges_seen = (edges_seen + 1) & 32'h1FF_FFFF;
      end
      c.cell_x         = i[9:0];
      c.cell_y         = j[6:0];
      c.cell_z         = k[6:0];
      c.is_void        = v;
      c.is_boundary    = b;
      c.void_count     = voids_seen[24:0];
      c.boundary_count = edges_seen[24:0];
      c.last_cell      = last;
      cells_due.push_back(c);
   endtask

   task automatic take_sample(logic signed [31:0] d);
      int unsigned x, y, z;
      bit last_plane, grid_end;
      longint sum;
      x = at_x;
      y = at_y;
      z = at_z;
      last_plane = (x == pts_x - 1);
      grid_end = last_plane && y == pts_y - 1 && z == pts_z - 1;
      samples[(x & 1) * PLANE + y * vvb_pkg::MAX_POINTS_Z + z] = d;
      if (x >= 1 && y >= 1 && z >= 1) begin
         sum = sample_of(x-1, y-1, z-1) + sample_of(x-1, y-1, z) + sample_of(x-1, y, z-1) +
               sample_of(x-1, y, z) + sample_of(x, y-1, z-1) + sample_of(x, y-1, z) +
               sample_of(x, y, z-1) + sample_of(x, y, z);
         void_flags[flag_at(x-1, y-1, z-1)] = (sum <= longint'(cutoff) * 8);
         if (x >= 2) finalise_cell(x - 2, y - 1, z - 1, 0);
         if (last_plane) finalise_cell(x - 1, y - 1, z - 1, grid_end);
      end
      if (grid_end) begin
         restart_grid();
      end else begin
         z++;
         if (z >= pts_z) begin
            z = 0;
            y++;
            if (y >= pts_y) begin
               y = 0;
               x++;
            end
         end
         at_x = x;
         at_y = y;
         at_z = z;
      end
   endtask

   task automatic check_cell();
      vvb_pkg::rsp_item_type w;
      if (cells_due.size() == 0) begin
         $display("[%0t] unexpected cell (%0d,%0d,%0d)", $time,
                  rsp_ch.cell_x, rsp_ch.cell_y, rsp_ch.cell_z);
         error_count++;
         return;
      end
      w = cells_due.pop_front();
      if (rsp_ch.cell_x !== w.cell_x) report_mismatch("cell_x", rsp_ch.cell_x, w.cell_x);
      if (rsp_ch.cell_y !== w.cell_y) report_mismatch("cell_y", rsp_ch.cell_y, w.cell_y);
      if (rsp_ch.cell_z !== w.cell_z) report_mismatch("cell_z", rsp_ch.cell_z, w.cell_z);
      if (rsp_ch.is_void !== w.is_void) report_mismatch("is_void", rsp_ch.is_void, w.is_void);
      if (rsp_ch.is_boundary !== w.is_boundary)
         report_mismatch("is_boundary", rsp_ch.is_boundary, w.is_boundary);
      if (rsp_ch.void_count !== w.void_count)
         report_mismatch("void_count", rsp_ch.void_count, w.void_count);
      if (rsp_ch.boundary_count !== w.boundary_count)
         report_mismatch("boundary_count", rsp_ch.boundary_count, w.boundary_count);
      if (rsp_ch.last_cell !== w.last_cell)
         report_mismatch("last_cell", rsp_ch.last_cell, w.last_cell);
   endtask

   initial begin
      error_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         pts_x = 2;
         pts_y = 2;
         pts_z = 2;
         cutoff = 0;
         restart_grid();
         cells_due.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               vvb_pkg::CSR_POINTS_X: begin
                  pts_x = clamp_pts(csr_ch.data, vvb_pkg::POINTS_X_LIMIT);
                  restart_grid();
               end
               vvb_pkg::CSR_POINTS_Y: begin
                  pts_y = clamp_pts(csr_ch.data, vvb_pkg::MAX_POINTS_Y);
                  restart_grid();
               end
               vvb_pkg::CSR_POINTS_Z: begin
                  pts_z = clamp_pts(csr_ch.data, vvb_pkg::MAX_POINTS_Z);
                  restart_grid();
               end
               vvb_pkg::CSR_THRESHOLD: cutoff = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) take_sample(req_ch.density);
         if (rsp_ch.valid && rsp_ch.ready) check_cell();
      end
      pending = cells_due.size();
   end

endmodule

@@ bench/voxel_void_boundary_classifier_tb.sv @@
`timescale 1ns / 1ps

module voxel_void_boundary_classifier_tb;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 16;
   localparam int CELL_CAP = 150;

   logic clock = 0;
   logic reset = 1;
   int   error_count, pending;
   int   samples_sent = 0;
   int   idle_cycles = 0;
   int   rsp_hold = 0;
   bit   calm = 0;
   logic signed [31:0] cutoff_now = 0;

   vvb_req_if req_ch ();
   vvb_rsp_if rsp_ch ();
   vvb_csr_if csr_ch ();

   voxel_void_boundary_classifier DUT (
      .clock (clock), .reset (reset),
      .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   voxel_classifier_checker checker_i (
      .clock (clock), .reset (reset),
      .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch),
      .error_count(error_count), .pending(pending)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly near the cutoff so void flags mix; some full-range and extreme values
   function automatic logic [31:0] pick_density();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return cutoff_now + $urandom_range(0, 64) - 32;
      if (r < 8) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= 1;
         if ($urandom_range(0, 5) == 0) rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("voxel_void_boundary_classifier_tb: errors");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 0;
      @(posedge clock);
      if (idx == vvb_pkg::CSR_THRESHOLD) cutoff_now = value;
   endtask

   task automatic send_sample(logic [31:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1;
      req_ch.density <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      samples_sent++;
   endtask

   // registers change only once every pending cell has drained
   task automatic wait_drained();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(int unsigned x, int unsigned y, int unsigned z, logic [31:0] thr);
      csr_write(vvb_pkg::CSR_POINTS_X, x);
      csr_write(vvb_pkg::CSR_POINTS_Y, y);
      csr_write(vvb_pkg::CSR_POINTS_Z, z);
      csr_write(vvb_pkg::CSR_THRESHOLD, thr);
   endtask

   task automatic send_random(int n);
      repeat (n) send_sample(pick_density());
   endtask

   initial begin
      int unsigned gx, gy, gz, cells;
      req_ch.valid   = 0;
      req_ch.density = 0;
      csr_ch.valid   = 0;
      csr_ch.index   = vvb_pkg::CSR_POINTS_X;
      csr_ch.data    = 0;
      rsp_ch.ready   = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes on the smallest grid: full-scale sums on both sides of the cutoff
      set_grid(2, 2, 2, 32'h0000_0000);
      send_sample(32'h7FFF_FFFF); send_sample(32'h8000_0000);
      send_sample(32'h0000_0000); send_sample(32'hFFFF_FFFF);
      send_sample(32'h0000_0001); send_sample(32'h5555_5555);
      send_sample(32'hAAAA_AAAA); send_sample(32'h0000_0000);
      wait_drained();
      // most negative sum equals most negative cutoff: still void
      csr_write(vvb_pkg::CSR_THRESHOLD, 32'h8000_0000);
      repeat (8) send_sample(32'h8000_0000);
      wait_drained();
      csr_write(vvb_pkg::CSR_THRESHOLD, 32'hFFFF_FFFF);
      repeat (8) send_sample(32'h0000_0000);
      wait_drained();
      // out-of-range sizes saturate; high cutoff makes every cell void
      set_grid(0, 1, 255, 32'h7FFF_FFFF);
      repeat (8) send_sample(32'h7FFF_FFFF);
      wait_drained();

      // random grids, mostly complete, sometimes cut short or run into the next
      while (samples_sent < 450) begin
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 4) != 0) begin
            gx = $urandom_range(2, 6);
            gy = $urandom_range(2, 7);
            gz = $urandom_range(2, 7);
            if ($urandom_range(0, 9) == 0) gz = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0) gy = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            set_grid(gx, gy, gz, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 512) - 256);
            gx = (gx < 2) ? 2 : gx;
            gy = (gy < 2) ? 2 : (gy > vvb_pkg::MAX_POINTS_Y) ? vvb_pkg::MAX_POINTS_Y : gy;
            gz = (gz < 2) ? 2 : gz;
            cells = gx * gy * gz;
            if (cells > CELL_CAP) cells = CELL_CAP;
            if ($urandom_range(0, 5) == 0) send_random($urandom_range(1, cells - 1));
            else send_random(cells * $urandom_range(1, 2));
         end else begin
            // cutoff change between grids, position kept
            csr_write(vvb_pkg::CSR_THRESHOLD, $urandom);
            send_random($urandom_range(1, 40));
         end
         wait_drained();
      end

      // largest sizes: saturated x axis partly, tallest y axis in full
      calm = 0;
      set_grid(2047, 2, 2, $urandom_range(0, 64) - 32);
      send_random(100);
      wait_drained();
      set_grid(2, 128, 2, 0);
      send_random(512);
      wait_drained();

      if (error_count == 0)
         $display("voxel_void_boundary_classifier_tb: clean");
      else
         $display("voxel_void_boundary_classifier_tb: errors");
      $finish;
   end

endmodule
